// ----- rtl/wkbgv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkbgv_pkg
// Shared types and constants for the binary geometry record validator:
// the input and result word layouts, type word limits and geometry kinds.
// ----------------------------------------------------------------------------
package wkbgv_pkg;

  // input word: one record byte and its end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // result word: verdict and base geometry kind
  typedef struct packed {
    logic       valid_res;
    logic [1:0] geometry_kind;
  } out_word_t;

  // geometry kinds as reported on the result word
  localparam logic [1:0] KindUnknown = 2'd0;
  localparam logic [1:0] KindPoint   = 2'd1;
  localparam logic [1:0] KindLine    = 2'd2;
  localparam logic [1:0] KindPolygon = 2'd3;

  // byte order codes
  localparam logic [7:0] OrderBig    = 8'd0;
  localparam logic [7:0] OrderLittle = 8'd1;

  // type word limits
  localparam logic [31:0] MetaFlags     = 32'hE000_0000;
  localparam logic [31:0] ReservedLo    = 32'd1000;
  localparam logic [31:0] ReservedHi    = 32'd4000;
  localparam logic [31:0] MinRingPoints = 32'd3;
  localparam logic [31:0] TypeMaskReset = 32'd255;

  // coordinate bytes per point (two doubles)
  localparam logic [35:0] PointBytes = 36'd16;

endpackage

// ----- rtl/wkb_geometry_validator.sv -----
`timescale 1ns / 1ps
// Path: the last byte of a record passes through the input register and then the result
// register before its result word can be taken.
// Throughput: one byte per cycle; the input register holds a last byte only while
// the result register still holds an untaken verdict.
// Reset (rst, synchronous): record state cleared, both registers empty, type mask 255.
// ----------------------------------------------------------------------------
// wkb_geometry_validator
// Streaming checker for binary geometry records, one byte per word. Walks the
// byte order, type word, counts and coordinate bytes of a point, line or
// polygon and gives one verdict at the last byte of each record.
// ----------------------------------------------------------------------------
module wkb_geometry_validator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wkbgv_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wkbgv_pkg::out_word_t  out_data,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data
);

  // record phase, one-hot
  typedef enum logic [6:0] {
    PhOrder  = 7'b000_0001,
    PhType   = 7'b000_0010,
    PhLcount = 7'b000_0100,
    PhLoops  = 7'b000_1000,
    PhRing   = 7'b001_0000,
    PhCoord  = 7'b010_0000,
    PhDone   = 7'b100_0000
  } phase_t;

  logic [31:0]          type_mask;
  logic                 stage_valid;
  wkbgv_pkg::in_word_t  stage;
  logic                 stage_adv;

  phase_t               phase, phase_next;
  logic [1:0]           byte_index, byte_index_next;
  logic                 little_endian, little_endian_next;
  logic [31:0]          word_accum, word_accum_next;
  logic [31:0]          loops_left, loops_left_next;
  logic [35:0]          coord_left, coord_left_next;
  logic                 failed, failed_next;
  logic [1:0]           kind, kind_next;

  logic [31:0]          word_full;
  logic                 word_done;
  logic [31:0]          base_type;
  logic                 type_bad;
  logic [35:0]          coord_dec;
  wkbgv_pkg::out_word_t res_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      type_mask <= wkbgv_pkg::TypeMaskReset;
    end else if (cfg_wr_en) begin
      type_mask <= cfg_wr_data;
    end
  end

  // input register: a last byte waits here while the result register is full
  assign stage_adv = stage_valid && !(stage.last_byte && out_valid && !out_ready);
  assign in_ready  = !stage_valid || stage_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_data;
    end
  end

  // word assembly in either byte order
  assign word_full = little_endian
                   ? (word_accum | ({24'd0, stage.data_byte} << {byte_index, 3'b000}))
                   : {word_accum[23:0], stage.data_byte};
  assign word_done = (byte_index == 2'd3);
  assign base_type = word_full & type_mask;
  assign type_bad  = ((word_full & wkbgv_pkg::MetaFlags) != 32'd0)
                   || ((word_full >= wkbgv_pkg::ReservedLo)
                       && (word_full < wkbgv_pkg::ReservedHi));
  assign coord_dec = (coord_left != 36'd0) ? (coord_left - 36'd1) : coord_left;

  // record walk for the byte in the input register
  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    little_endian_next = little_endian;
    word_accum_next    = word_accum;
    loops_left_next    = loops_left;
    coord_left_next    = coord_left;
    failed_next        = failed;
    kind_next          = kind;
    res_next           = '0;
    if (stage_adv) begin
      if (!failed) begin
        case (phase)
          PhOrder: begin
            if (stage.data_byte == wkbgv_pkg::OrderLittle) begin
              little_endian_next = 1'b1;
              byte_index_next    = 2'd0;
              word_accum_next    = 32'd0;
              phase_next         = PhType;
            end else if (stage.data_byte == wkbgv_pkg::OrderBig) begin
              little_endian_next = 1'b0;
              byte_index_next    = 2'd0;
              word_accum_next    = 32'd0;
              phase_next         = PhType;
            end else begin
              failed_next = 1'b1;
            end
          end
          PhType, PhLcount, PhLoops, PhRing: begin
            if (!word_done) begin
              word_accum_next = word_full;
              byte_index_next = byte_index + 2'd1;
            end else begin
              word_accum_next = 32'd0;
              byte_index_next = 2'd0;
              if (phase == PhType) begin
                if (type_bad) begin
                  failed_next = 1'b1;
                end else if (base_type == 32'd1) begin
                  kind_next       = wkbgv_pkg::KindPoint;
                  coord_left_next = wkbgv_pkg::PointBytes;
                  phase_next      = PhCoord;
                end else if (base_type == 32'd2) begin
                  kind_next  = wkbgv_pkg::KindLine;
                  phase_next = PhLcount;
                end else if (base_type == 32'd3) begin
                  kind_next  = wkbgv_pkg::KindPolygon;
                  phase_next = PhLoops;
                end else begin
                  failed_next = 1'b1;
                end
              end else if (phase == PhLcount) begin
                if (word_full == 32'd0) begin
                  failed_next = 1'b1;
                end else begin
                  coord_left_next = {word_full, 4'b0000};
                  phase_next      = PhCoord;
                end
              end else if (phase == PhLoops) begin
                if (word_full == 32'd0) begin
                  failed_next = 1'b1;
                end else begin
                  loops_left_next = word_full;
                  phase_next      = PhRing;
                end
              end else begin
                if (word_full < wkbgv_pkg::MinRingPoints) begin
                  failed_next = 1'b1;
                end else begin
                  coord_left_next = {word_full, 4'b0000};
                  loops_left_next = loops_left - 32'd1;
                  phase_next      = PhCoord;
                end
              end
            end
          end
          PhCoord: begin
            coord_left_next = coord_dec;
            if (coord_dec == 36'd0) begin
              phase_next = (loops_left != 32'd0) ? PhRing : PhDone;
            end
          end
          default: begin
            // trailing byte after a complete geometry, or an unused code
            failed_next = 1'b1;
          end
        endcase
      end
      // verdict at the last byte, then a fresh record
      if (stage.last_byte) begin
        if (!failed_next && (phase_next == PhDone)) begin
          res_next.valid_res     = 1'b1;
          res_next.geometry_kind = kind_next;
        end else begin
          res_next.valid_res     = 1'b0;
          res_next.geometry_kind = wkbgv_pkg::KindUnknown;
        end
        phase_next         = PhOrder;
        byte_index_next    = 2'd0;
        little_endian_next = 1'b0;
        word_accum_next    = 32'd0;
        loops_left_next    = 32'd0;
        coord_left_next    = 36'd0;
        failed_next        = 1'b0;
        kind_next          = wkbgv_pkg::KindUnknown;
      end
    end
  end

  // record state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhOrder;
      byte_index    <= 2'd0;
      little_endian <= 1'b0;
      word_accum    <= 32'd0;
      loops_left    <= 32'd0;
      coord_left    <= 36'd0;
      failed        <= 1'b0;
      kind          <= wkbgv_pkg::KindUnknown;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      little_endian <= little_endian_next;
      word_accum    <= word_accum_next;
      loops_left    <= loops_left_next;
      coord_left    <= coord_left_next;
      failed        <= failed_next;
      kind          <= kind_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv && stage.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage.last_byte) begin
      out_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  // a passing verdict always names a geometry
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res |-> out_data.geometry_kind != wkbgv_pkg::KindUnknown)
    else $error("passing verdict without geometry kind");

  // a failing verdict carries no geometry
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |-> out_data.geometry_kind == wkbgv_pkg::KindUnknown)
    else $error("failing verdict with geometry kind");

  // the record state is cleared after its last byte
  assert property (@(posedge clk) disable iff (rst)
    stage_adv && stage.last_byte |=> phase == PhOrder && !failed && coord_left == 36'd0)
    else $error("record state not cleared after last byte");

  // coordinate phase always has bytes still to come
  assert property (@(posedge clk) disable iff (rst)
    phase == PhCoord |-> coord_left != 36'd0)
    else $error("coordinate phase with no bytes left");

  // input stalls only behind a pending verdict
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && stage.last_byte && out_valid && !out_ready)
    else $error("input stalled without a pending verdict");
`endif

endmodule

// ----- dv/wkb_geometry_validator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wkb_geometry_validator_tb
// Self-checking bench for the binary geometry record validator. Points, lines,
// polygons, broken headers, bad counts, framing faults and noise are streamed
// one byte per word. Both sides idle in random bursts, and the result side
// holds off once for a long stretch. Each verdict word is checked against an
// in-bench walk of the record, and the type mask moves through several values.
// ----------------------------------------------------------------------------
module wkb_geometry_validator_tb;

  localparam int LongHold = 300;

  // record walk phases, one-hot
  typedef enum logic [6:0] {
    PhOrder     = 7'b000_0001,
    PhType      = 7'b000_0010,
    PhLineCount = 7'b000_0100,
    PhLoopCount = 7'b000_1000,
    PhRingCount = 7'b001_0000,
    PhCoords    = 7'b010_0000,
    PhDone      = 7'b100_0000
  } rec_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  wkbgv_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wkbgv_pkg::out_word_t out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [31:0]          cfg_wr_data = '0;

  // pacing
  logic idle_on = 1'b0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   rx_hold = 0;

  // record walk state
  logic [31:0] mask_q;
  rec_phase_t  rec_phase;
  logic [1:0]  rec_idx;
  logic        rec_le;
  logic [31:0] rec_word;
  logic [31:0] loops_left;
  logic [35:0] coord_left;
  logic        rec_failed;
  logic [1:0]  rec_kind;

  wkbgv_pkg::out_word_t verdicts_due[$];
  logic [7:0]           rec_bytes[$];
  int                   fail_count = 0;
  int                   bytes_fed = 0;

  always #2 clk = ~clk;

  wkb_geometry_validator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic void clear_record();
    rec_phase = PhOrder;
    rec_idx = '0;
    rec_le = 1'b0;
    rec_word = '0;
    loops_left = '0;
    coord_left = '0;
    rec_failed = 1'b0;
    rec_kind = wkbgv_pkg::KindUnknown;
  endfunction

  // advance the record walk by one accepted byte
  function automatic void walk_byte(logic [7:0] b);
    logic [31:0] w;
    logic [31:0] base;
    if (rec_failed) return;
    case (rec_phase)
      PhOrder: begin
        if (b == wkbgv_pkg::OrderLittle || b == wkbgv_pkg::OrderBig) begin
          rec_le = (b == wkbgv_pkg::OrderLittle);
          rec_idx = '0;
          rec_word = '0;
          rec_phase = PhType;
        end else begin
          rec_failed = 1'b1;
        end
      end
      PhType, PhLineCount, PhLoopCount, PhRingCount: begin
        if (rec_le) rec_word = rec_word | ({24'd0, b} << (8 * rec_idx));
        else rec_word = {rec_word[23:0], b};
        if (rec_idx != 2'd3) begin
          rec_idx = rec_idx + 2'd1;
          return;
        end
        rec_idx = '0;
        w = rec_word;
        rec_word = '0;
        case (rec_phase)
          PhType: begin
            base = w & mask_q;
            if ((w & wkbgv_pkg::MetaFlags) != '0
                || (w >= wkbgv_pkg::ReservedLo && w < wkbgv_pkg::ReservedHi)) begin
              rec_failed = 1'b1;
            end else if (base == {30'd0, wkbgv_pkg::KindPoint}) begin
              rec_kind = wkbgv_pkg::KindPoint;
              coord_left = wkbgv_pkg::PointBytes;
              rec_phase = PhCoords;
            end else if (base == {30'd0, wkbgv_pkg::KindLine}) begin
              rec_kind = wkbgv_pkg::KindLine;
              rec_phase = PhLineCount;
            end else if (base == {30'd0, wkbgv_pkg::KindPolygon}) begin
              rec_kind = wkbgv_pkg::KindPolygon;
              rec_phase = PhLoopCount;
            end else begin
              rec_failed = 1'b1;
            end
          end
          PhLineCount: begin
            if (w == '0) begin
              rec_failed = 1'b1;
            end else begin
              coord_left = {w, 4'd0};
              rec_phase = PhCoords;
            end
          end
          PhLoopCount: begin
            if (w == '0) begin
              rec_failed = 1'b1;
            end else begin
              loops_left = w;
              rec_phase = PhRingCount;
            end
          end
          default: begin
            if (w < wkbgv_pkg::MinRingPoints) begin
              rec_failed = 1'b1;
            end else begin
              coord_left = {w, 4'd0};
              loops_left = loops_left - 32'd1;
              rec_phase = PhCoords;
            end
          end
        endcase
      end
      PhCoords: begin
        if (coord_left != '0) coord_left = coord_left - 36'd1;
        if (coord_left == '0) rec_phase = (loops_left != '0) ? PhRingCount : PhDone;
      end
      // trailing bytes after a complete geometry
      default: rec_failed = 1'b1;
    endcase
  endfunction

  // offer one word, wait for it to be taken, then update the walk
  task automatic send_byte(input logic [7:0] b, input logic last);
    wkbgv_pkg::in_word_t  w;
    wkbgv_pkg::out_word_t v;
    w.data_byte = b;
    w.last_byte = last;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    bytes_fed++;
    walk_byte(b);
    if (last) begin
      v.valid_res = !rec_failed && rec_phase == PhDone;
      v.geometry_kind = v.valid_res ? rec_kind : wkbgv_pkg::KindUnknown;
      verdicts_due.push_back(v);
      clear_record();
    end
  endtask

  task automatic send_record();
    foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  // stop feeding and let every verdict come back
  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_type_mask(input logic [31:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    mask_q = m;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void put_word(logic le, logic [31:0] w);
    for (int i = 0; i < 4; i++)
      rec_bytes.push_back(le ? w[8*i +: 8] : w[8*(3-i) +: 8]);
  endfunction

  function automatic void put_coords(int points);
    for (int i = 0; i < points * 16; i++) rec_bytes.push_back(8'($urandom));
  endfunction

  // keep only the first bytes of a record that fails early anyway
  function automatic void cut_record(int keep);
    while (rec_bytes.size() > keep) void'(rec_bytes.pop_back());
  endfunction

  // lay out a record; huge counts get a short body so the record ends early
  function automatic void build_record(logic le, logic [1:0] shape, logic [31:0] tw,
                                       logic [31:0] n_a, logic [31:0] n_b);
    rec_bytes.delete();
    rec_bytes.push_back(le ? wkbgv_pkg::OrderLittle : wkbgv_pkg::OrderBig);
    put_word(le, tw);
    case (shape)
      wkbgv_pkg::KindPoint: put_coords(1);
      wkbgv_pkg::KindLine: begin
        put_word(le, n_a);
        put_coords(n_a > 4 ? 1 : n_a);
      end
      wkbgv_pkg::KindPolygon: begin
        put_word(le, n_a);
        for (int k = 0; k < (n_a > 3 ? 1 : n_a); k++) begin
          put_word(le, n_b);
          put_coords(n_b > 4 ? 1 : n_b);
        end
      end
      default: ;
    endcase
  endfunction

  // mostly well-formed records with random content, some broken or noise
  function automatic void random_record(logic [31:0] mask);
    logic        le;
    logic [1:0]  shape;
    logic [31:0] tw;
    int          pick;
    int          cut;
    le = 1'($urandom);
    shape = 2'($urandom_range(1, 3));
    tw = ($urandom & ~mask & ~wkbgv_pkg::MetaFlags) | {30'd0, shape};
    pick = $urandom_range(0, 23);
    if (pick == 0) tw = tw | (32'h2000_0000 << $urandom_range(0, 2));
    if (pick == 7) tw = wkbgv_pkg::ReservedLo + $urandom_range(0, 2999);
    build_record(le, shape, tw, $urandom_range(1, shape == wkbgv_pkg::KindLine ? 3 : 2),
                 $urandom_range(3, 4));
    case (pick)
      // pure noise
      1: begin
        rec_bytes.delete();
        repeat ($urandom_range(1, 6)) rec_bytes.push_back(8'($urandom));
      end
      // early end
      2: begin
        cut = $urandom_range(1, rec_bytes.size() - 1);
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
      end
      // trailing bytes
      3: repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
      // corrupted byte among the first thirteen of the record
      4: rec_bytes[$urandom_range(0, 12)] = 8'($urandom);
      // zero first count
      5: for (int i = 5; i < 9; i++) rec_bytes[i] = 8'h00;
      // short polygon loop
      6: if (shape == wkbgv_pkg::KindPolygon) build_record(le, shape, tw, 1,
                                                           $urandom_range(0, 2));
      default: ;
    endcase
  endfunction

  task automatic run_random(input int n_bytes, input int n_records);
    int stop_bytes;
    stop_bytes = bytes_fed + n_bytes;
    for (int r = 0; r < n_records || bytes_fed < stop_bytes; r++) begin
      random_record(mask_q);
      send_record();
    end
  endtask

  task automatic test_valid_shapes();
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    for (int i = 5; i < rec_bytes.size(); i++) rec_bytes[i] = 8'hFF;
    send_record();
    build_record(1'b0, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    for (int i = 5; i < rec_bytes.size(); i++) rec_bytes[i] = 8'h00;
    send_record();
    build_record(1'b1, wkbgv_pkg::KindLine, 32'd2, 32'd2, '0);
    send_record();
    // upper type bits outside the mask are dropped
    build_record(1'b0, wkbgv_pkg::KindPolygon, 32'h1FFF_FF03, 32'd2, 32'd3);
    send_record();
  endtask

  task automatic test_bad_headers();
    // lone order byte that is not an order code
    rec_bytes.delete();
    rec_bytes.push_back(8'hFF);
    send_record();
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    rec_bytes[0] = 8'h02;
    cut_record(6);
    send_record();
    // flag bits and reserved range
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'hE000_0001, '0, '0);
    cut_record(6);
    send_record();
    build_record(1'b0, wkbgv_pkg::KindPoint, 32'h0000_0401, '0, '0);
    cut_record(6);
    send_record();
    // unsupported base types
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd0, '0, '0);
    cut_record(6);
    send_record();
    build_record(1'b0, wkbgv_pkg::KindPoint, 32'd4, '0, '0);
    cut_record(6);
    send_record();
  endtask

  task automatic test_bad_counts();
    build_record(1'b1, wkbgv_pkg::KindLine, 32'd2, 32'd0, '0);
    send_record();
    build_record(1'b0, wkbgv_pkg::KindPolygon, 32'd3, 32'd0, '0);
    send_record();
    build_record(1'b1, wkbgv_pkg::KindPolygon, 32'd3, 32'd1, 32'd2);
    cut_record(14);
    send_record();
    // count far beyond the record length
    build_record(1'b0, wkbgv_pkg::KindLine, 32'd2, 32'hFFFF_FFFF, '0);
    send_record();
  endtask

  task automatic test_framing();
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    void'(rec_bytes.pop_back());
    send_record();
    build_record(1'b0, wkbgv_pkg::KindLine, 32'd2, 32'd1, '0);
    rec_bytes.push_back(8'h00);
    send_record();
    rec_bytes.delete();
    rec_bytes.push_back(wkbgv_pkg::OrderLittle);
    send_record();
  endtask

  task automatic test_type_mask();
    set_type_mask(32'hFFFF_FFFF);
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    send_record();
    build_record(1'b0, wkbgv_pkg::KindPoint, 32'h0000_0101, '0, '0);
    cut_record(6);
    send_record();
    set_type_mask(32'h0000_0000);
    build_record(1'b1, wkbgv_pkg::KindLine, 32'd2, 32'd1, '0);
    cut_record(6);
    send_record();
    set_type_mask(32'h0000_FF00);
    build_record(1'b0, wkbgv_pkg::KindPolygon, 32'h0000_0300, 32'd1, 32'd3);
    cut_record(6);
    send_record();
    set_type_mask(wkbgv_pkg::TypeMaskReset);
  endtask

  // result side holds off while short records keep coming
  task automatic test_backpressure();
    hold_asked <= hold_asked + 1;
    repeat (12) begin
      rec_bytes.delete();
      rec_bytes.push_back(8'($urandom_range(2, 255)));
      send_record();
    end
    build_record(1'b1, wkbgv_pkg::KindPoint, 32'd1, '0, '0);
    send_record();
  endtask

  task automatic test_random();
    run_random(20, 1);
    set_type_mask($urandom | 32'd3);
    run_random(20, 1);
    set_type_mask(wkbgv_pkg::TypeMaskReset);
    idle_on <= 1'b0;
    run_random(30, 1);
  endtask

  // result side pacing
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (hold_served != hold_asked) begin
      out_ready <= 1'b0;
      rx_hold <= LongHold;
      hold_served <= hold_served + 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // verdict check against the oldest pending word
  always @(posedge clk) begin
    wkbgv_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict word %b with none pending", out_data);
        fail_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.valid_res !== want.valid_res) begin
          $error("valid_res expected %0b got %0b", want.valid_res, out_data.valid_res);
          fail_count++;
        end
        if (out_data.geometry_kind !== want.geometry_kind) begin
          $error("geometry_kind expected %0d got %0d",
                 want.geometry_kind, out_data.geometry_kind);
          fail_count++;
        end
      end
    end
  end

  initial begin
    mask_q = wkbgv_pkg::TypeMaskReset;
    clear_record();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;
    test_valid_shapes();
    test_bad_headers();
    test_bad_counts();
    test_framing();
    test_type_mask();
    test_backpressure();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
